// ----- rtl/sorted_table_binary_search_macros.svh -----
// Assertion macros for the sorted table search block.
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/sts_pkg.sv -----
`timescale 1ns / 1ps

package sts_pkg;

   localparam int TABLE_DEPTH_DEF = 256;
   localparam int VALUE_BITS_DEF  = 32;

   localparam int OP_W    = 1;
   localparam int SLOT_W  = 8;
   localparam int KEY_W   = 32;
   localparam int POS_W   = 8;
   localparam int COUNT_W = 9;

   localparam logic [OP_W-1:0] OP_LOAD   = 1'b0;
   localparam logic [OP_W-1:0] OP_SEARCH = 1'b1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_ENTRIES = '0;

   localparam logic [COUNT_W-1:0] ENTRIES_RESET = 9'd256;

endpackage

// ----- rtl/sts_req_if.sv -----
`timescale 1ns / 1ps

interface sts_req_if;
   import sts_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         op;
   logic [SLOT_W-1:0]       slot;
   logic signed [KEY_W-1:0] value;

   modport source (output valid, output op, output slot, output value, input ready);
   modport sink (input valid, input op, input slot, input value, output ready);

endinterface

// ----- rtl/sts_rsp_if.sv -----
`timescale 1ns / 1ps

interface sts_rsp_if;
   import sts_pkg::*;

   logic             valid;
   logic             ready;
   logic             found;
   logic [POS_W-1:0] position;

   modport source (output valid, output found, output position, input ready);
   modport sink (input valid, input found, input position, output ready);

endinterface

// ----- rtl/sorted_table_binary_search.sv -----
// Sorted table with binary search. Requests with op = load write one table entry and mark
// the table unsorted; requests with op = search return found and the sorted-order
// position (0 when absent). The table sits in a single RAM with one write and one
// registered read port, and that port sets the timing. A search on a sorted table takes
// k probe steps, at most ceil(log2(n + 1)) for n entries in use. The first search after
// a load or a write of entries_in_use first sorts the table in place. Each pass
// i = 0 .. n - 2 holds entry i, swaps it with each smaller entry above it, and writes the
// smallest value back at entry i.
// Responses are held in an output register, so loads are taken while a response waits.
// Searching entries that were never loaded gives undefined results.
`timescale 1ns / 1ps
`include "sorted_table_binary_search_macros.svh"

module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF,
   parameter int VALUE_BITS  = sts_pkg::VALUE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   sts_req_if.sink                        req,
   sts_rsp_if.source                      rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sts_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sts_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [sts_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import sts_pkg::*;

   localparam int IDX_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W      = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int SLOT_COUNT = 2 ** SLOT_W;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_HEAD   = 7'b0000010,
      ST_SCAN   = 7'b0000100,
      ST_STORE  = 7'b0001000,
      ST_START  = 7'b0010000,
      ST_PROBE  = 7'b0100000,
      ST_RESULT = 7'b1000000
   } state_type;

   function automatic logic [IDX_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                               input logic [CNT_W-1:0] hi1);
      logic [CNT_W:0] sum;
      sum = {1'b0, lo} + {1'b0, hi1} - (CNT_W + 1)'(1);
      return IDX_W'(sum >> 1);
   endfunction

   state_type               state_ff, state_in;
   logic [COUNT_W-1:0]      entries_ff, entries_in;
   logic                    sorted_ff, sorted_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic signed [VALUE_BITS-1:0] key_ff, key_in;
   logic signed [VALUE_BITS-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0]        i_ff, i_in;
   logic [IDX_W-1:0]        j_ff, j_in;
   logic [CNT_W-1:0]        lo_ff, lo_in;
   logic [CNT_W-1:0]        hi1_ff, hi1_in;
   logic [IDX_W-1:0]        mid_ff, mid_in;
   logic                    hit_ff, hit_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]        rsp_pos_ff, rsp_pos_in;

   logic [IDX_W-1:0]             slot_map [SLOT_COUNT];
   logic signed [VALUE_BITS-1:0] value_conv;
   logic [CMP_W-1:0]             entries_ext;
   logic [CNT_W-1:0]             n_cur;
   logic                         req_take;
   logic                         csr_write;

   logic                         ram_we;
   logic [IDX_W-1:0]             ram_waddr;
   logic [VALUE_BITS-1:0]        ram_wdata;
   logic [IDX_W-1:0]             ram_raddr;
   logic [VALUE_BITS-1:0]        ram_rdata;
   logic signed [VALUE_BITS-1:0] rd_val;

   logic                         probe_hit;
   logic                         probe_lt;
   logic [CNT_W-1:0]             lo_nx;
   logic [CNT_W-1:0]             hi1_nx;

   for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot_map
      assign slot_map[g] = IDX_W'(g % TABLE_DEPTH);
   end

   assign value_conv  = VALUE_BITS'(req.value);
   assign entries_ext = CMP_W'(entries_ff);
   assign n_cur = (entries_ext == '0) ? CNT_W'(1) :
                  (entries_ext > CMP_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) :
                  CNT_W'(entries_ext);

   assign req.ready = (state_ff == ST_IDLE);
   assign req_take  = req.valid && req.ready;
   assign csr_write = psel && penable && pwrite && pready;

   assign pready = 1'b1;
   assign prdata = (paddr[CSR_ADDR_W-1:2] == CSR_IDX_ENTRIES) ? CSR_DATA_W'(entries_ff) : '0;

   assign rd_val    = $signed(ram_rdata);
   assign probe_hit = (rd_val == key_ff);
   assign probe_lt  = (rd_val < key_ff);
   assign lo_nx     = probe_lt ? CNT_W'(mid_ff) + CNT_W'(1) : lo_ff;
   assign hi1_nx    = (!probe_lt && !probe_hit) ? CNT_W'(mid_ff) : hi1_ff;

   always_comb begin
      unique case (state_ff)
         ST_IDLE:  ram_raddr = '0;
         ST_HEAD:  ram_raddr = i_ff + IDX_W'(1);
         ST_SCAN:  ram_raddr = j_ff + IDX_W'(1);
         ST_STORE: ram_raddr = i_ff + IDX_W'(1);
         ST_START: ram_raddr = mid_of(lo_ff, hi1_ff);
         ST_PROBE: ram_raddr = mid_of(lo_nx, hi1_nx);
         default:  ram_raddr = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      entries_in   = entries_ff;
      sorted_in    = sorted_ff;
      n_in         = n_ff;
      key_in       = key_ff;
      cur_in       = cur_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      lo_in        = lo_ff;
      hi1_in       = hi1_ff;
      mid_in       = mid_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      ram_we       = 1'b0;
      ram_waddr    = i_ff;
      ram_wdata    = cur_ff;

      if (csr_write && (paddr[CSR_ADDR_W-1:2] == CSR_IDX_ENTRIES)) begin
         entries_in = pwdata[COUNT_W-1:0];
         sorted_in  = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req.op == OP_LOAD) begin
                  ram_we    = 1'b1;
                  ram_waddr = slot_map[req.slot];
                  ram_wdata = value_conv;
                  sorted_in = 1'b0;
               end else begin
                  key_in = value_conv;
                  n_in   = n_cur;
                  if (!sorted_ff && (n_cur > CNT_W'(1))) begin
                     i_in     = '0;
                     state_in = ST_HEAD;
                  end else begin
                     sorted_in = 1'b1;
                     lo_in     = '0;
                     hi1_in    = n_cur;
                     state_in  = ST_START;
                  end
               end
            end
         end
         ST_HEAD: begin
            cur_in   = rd_val;
            j_in     = i_ff + IDX_W'(1);
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (rd_val < cur_ff) begin
               ram_we    = 1'b1;
               ram_waddr = j_ff;
               ram_wdata = cur_ff;
               cur_in    = rd_val;
            end
            if (CNT_W'(j_ff) + CNT_W'(1) < n_ff) begin
               j_in = j_ff + IDX_W'(1);
            end else begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            ram_we    = 1'b1;
            ram_waddr = i_ff;
            ram_wdata = cur_ff;
            if (CNT_W'(i_ff) + CNT_W'(2) < n_ff) begin
               i_in     = i_ff + IDX_W'(1);
               state_in = ST_HEAD;
            end else begin
               sorted_in = 1'b1;
               lo_in     = '0;
               hi1_in    = n_ff;
               state_in  = ST_START;
            end
         end
         ST_START: begin
            mid_in   = mid_of(lo_ff, hi1_ff);
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            lo_in  = lo_nx;
            hi1_in = hi1_nx;
            if (probe_hit || (lo_nx >= hi1_nx)) begin
               hit_in   = probe_hit;
               state_in = ST_RESULT;
            end else begin
               mid_in = mid_of(lo_nx, hi1_nx);
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_pos_in   = hit_ff ? POS_W'(mid_ff) : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         entries_ff   <= ENTRIES_RESET;
         sorted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         entries_ff   <= entries_in;
         sorted_ff    <= sorted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff       <= n_in;
      key_ff     <= key_in;
      cur_ff     <= cur_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      lo_ff      <= lo_in;
      hi1_ff     <= hi1_in;
      mid_ff     <= mid_in;
      hit_ff     <= hit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.found    = rsp_found_ff;
   assign rsp.position = rsp_pos_ff;

   sts_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   `STS_ASSERT_SAME(a_scan_range, clock, reset, state_ff == ST_SCAN, (j_ff > i_ff) && (CNT_W'(j_ff) < n_ff), "sort scan index out of range")
   `STS_ASSERT_SAME(a_search_sorted, clock, reset, state_ff == ST_START, sorted_ff && (lo_ff < hi1_ff), "search started on unsorted table")
   `STS_ASSERT_SAME(a_miss_pos_zero, clock, reset, rsp.valid && !rsp.found, rsp.position == '0, "miss response with nonzero position")
   `STS_ASSERT_NEXT(a_result_slot, clock, reset, (state_ff == ST_RESULT) && (!rsp_valid_ff || rsp.ready), rsp_valid_ff && (state_ff == ST_IDLE), "result not delivered to output register")

endmodule

// ----- rtl/sts_ram.sv -----
`timescale 1ns / 1ps

module sts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
